>>> sv/ry420_pkg.sv
// Shared types, constants and helper functions for the RGB to YCbCr 4:2:0 block tiler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ry420_pkg;

    // Q16 coefficient magnitudes; signs are applied in the summing stage
    localparam int unsigned K_Y_R  = 19595;
    localparam int unsigned K_Y_G  = 38470;
    localparam int unsigned K_Y_B  = 7471;
    localparam int unsigned K_CB_R = 11076;
    localparam int unsigned K_CB_G = 21692;
    localparam int unsigned K_CB_B = 32702;
    localparam int unsigned K_CR_R = 32702;
    localparam int unsigned K_CR_G = 27394;
    localparam int unsigned K_CR_B = 5328;
    localparam int unsigned CHROMA_OFFSET = 128 << 16;

    localparam int PROD_W = 24;
    localparam int SUM_W  = 26;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam int unsigned WIDTH_RESET  = 640;
    localparam int unsigned HEIGHT_RESET = 480;

    typedef logic [PROD_W-1:0]       t_prod;
    typedef logic signed [SUM_W-1:0] t_sum;

    // pipeline load enables, one per stage boundary
    typedef struct packed {
        logic ld_b;
        logic ld_c;
        logic ld_d;
    } t_pipe_en;

    typedef struct packed {
        logic col_odd;
        logic row_odd;
    } t_pix_ctl;

    typedef struct packed {
        logic       valid;
        logic [7:0] cb_avg;
        logic [7:0] cr_avg;
    } t_chroma_res;

    function automatic logic [7:0] clamp_q16(input t_sum acc);
        logic signed [SUM_W-1:0] v;
        v = acc >>> 16;
        if (acc < 0) begin
            return 8'd0;
        end else if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // clear low three bits, then hold within 8..mx
    function automatic logic [31:0] eff_size(input logic [31:0] v, input logic [31:0] mx);
        logic [31:0] s;
        s = v & ~32'd7;
        if (s < 32'd8) begin
            s = 32'd8;
        end
        if (s > mx) begin
            s = mx;
        end
        return s;
    endfunction

endpackage

>>> sv/ry420_csc.sv
// Color space converter: RGB to Y, Cb, Cr with Q16 coefficients, floored and clamped.
// Two register stages (products, sums); depends on ry420_pkg.
`timescale 1ns / 1ps

module ry420_csc import ry420_pkg::*; (
    input  logic       i_clk,
    input  t_pipe_en   i_en,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic [7:0] o_luma,
    output logic [7:0] o_cb,
    output logic [7:0] o_cr
);

    t_prod r_y_r, r_y_g, r_y_b;
    t_prod r_cb_r, r_cb_g, r_cb_b;
    t_prod r_cr_r, r_cr_g, r_cr_b;
    t_sum  r_y_sum, r_cb_sum, r_cr_sum;
    t_sum  n_y_sum, n_cb_sum, n_cr_sum;

    always_ff @(posedge i_clk) begin
        if (i_en.ld_b) begin
            r_y_r  <= PROD_W'(K_Y_R  * 32'(i_red));
            r_y_g  <= PROD_W'(K_Y_G  * 32'(i_green));
            r_y_b  <= PROD_W'(K_Y_B  * 32'(i_blue));
            r_cb_r <= PROD_W'(K_CB_R * 32'(i_red));
            r_cb_g <= PROD_W'(K_CB_G * 32'(i_green));
            r_cb_b <= PROD_W'(K_CB_B * 32'(i_blue));
            r_cr_r <= PROD_W'(K_CR_R * 32'(i_red));
            r_cr_g <= PROD_W'(K_CR_G * 32'(i_green));
            r_cr_b <= PROD_W'(K_CR_B * 32'(i_blue));
        end
    end

    always_comb begin
        n_y_sum  = t_sum'({2'b00, r_y_r}) + t_sum'({2'b00, r_y_g}) + t_sum'({2'b00, r_y_b});
        n_cb_sum = t_sum'(CHROMA_OFFSET) - t_sum'({2'b00, r_cb_r})
                 - t_sum'({2'b00, r_cb_g}) + t_sum'({2'b00, r_cb_b});
        n_cr_sum = t_sum'(CHROMA_OFFSET) + t_sum'({2'b00, r_cr_r})
                 - t_sum'({2'b00, r_cr_g}) - t_sum'({2'b00, r_cr_b});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_c) begin
            r_y_sum  <= n_y_sum;
            r_cb_sum <= n_cb_sum;
            r_cr_sum <= n_cr_sum;
        end
    end

    assign o_luma = clamp_q16(r_y_sum);
    assign o_cb   = clamp_q16(r_cb_sum);
    assign o_cr   = clamp_q16(r_cr_sum);

endmodule

>>> sv/ry420_chroma.sv
// 4:2:0 chroma averaging: line memory of even-row pair sums plus the left-pixel register.
// Read issued one stage ahead of use; depends on ry420_pkg.
`timescale 1ns / 1ps

module ry420_chroma import ry420_pkg::*; #(
    parameter int LINE_DEPTH = 512,
    parameter int LAW = $clog2(LINE_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_pipe_en       i_en,
    input  logic [LAW-1:0] i_rd_idx,
    input  logic [LAW-1:0] i_wr_idx,
    input  t_pix_ctl       i_ctl,
    input  logic [7:0]     i_cb,
    input  logic [7:0]     i_cr,
    output t_chroma_res    o_chroma
);

    // {cr pair sum, cb pair sum}, 9 bits each
    logic [17:0] mem [LINE_DEPTH];
    logic [17:0] r_rd;
    logic [15:0] r_left;
    logic [8:0]  cb_pair, cr_pair;
    logic [9:0]  cb_quad, cr_quad;

    assign cb_pair = {1'b0, r_left[7:0]}  + {1'b0, i_cb};
    assign cr_pair = {1'b0, r_left[15:8]} + {1'b0, i_cr};
    assign cb_quad = {1'b0, r_rd[8:0]}  + {1'b0, cb_pair};
    assign cr_quad = {1'b0, r_rd[17:9]} + {1'b0, cr_pair};

    // read data holds while the consuming stage stalls
    always_ff @(posedge i_clk) begin
        if (i_en.ld_c) begin
            r_rd <= mem[i_rd_idx];
        end
    end

    // an entry is written on an even row and read a full row later: no overlap
    always_ff @(posedge i_clk) begin
        if (i_en.ld_d && i_ctl.col_odd && !i_ctl.row_odd) begin
            mem[i_wr_idx] <= {cr_pair, cb_pair};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_en.ld_d && !i_ctl.col_odd) begin
            r_left <= {i_cr, i_cb};
        end
    end

    always_comb begin
        o_chroma = '0;
        if (i_ctl.col_odd && i_ctl.row_odd) begin
            o_chroma.valid  = 1'b1;
            o_chroma.cb_avg = cb_quad[9:2];
            o_chroma.cr_avg = cr_quad[9:2];
        end
    end

endmodule

>>> sv/rgb_to_ycbcr_420_block_tiler.sv
// Top level of the RGB to YCbCr 4:2:0 block tiler: stream handshake, counters, tiling.
// Uses ry420_pkg, ry420_csc and ry420_chroma.
`timescale 1ns / 1ps

// Takes one RGB pixel per clock in raster order and returns one result per pixel:
// luma, 8x8 block number and position, and on odd-row/odd-column pixels the 2x2
// Cb/Cr averages with their 4x4 position; tlast marks the last pixel of a frame.
// Sustained rate is one pixel per cycle while the output is not stalled; each pixel passes
// the input register, product stage, sum/read stage and output register in that order,
// and output valid rises when the output register is loaded. The line memory holds
// MAX_WIDTH/2 entries of 18 bits, is read at most once and written at most once
// per cycle, and needs no clearing pass after reset. Sizes must be written through
// the config port only while the stream is idle; the block itself does not enforce it.
module rgb_to_ycbcr_420_block_tiler import ry420_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // luma[7:0], block_index[23:8], luma_position[29:24], cb_average[37:30],
    // cr_average[45:38], chroma_position[49:46], zero[55:50]
    output logic [55:0]           o_m_axis_tdata,
    output logic                  o_m_axis_tlast,  // frame_last
    output logic                  o_m_axis_tuser,  // chroma_valid
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LAW = $clog2(LINE_DEPTH);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int HEW = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = (RW - 3) + (WEW - 3);

    t_pipe_en en;
    logic     accept, col_wrap, row_wrap;

    logic [WEW-1:0] r_eff_w;
    logic [HEW-1:0] r_eff_h;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;

    // stage A: input register
    logic          r_a_valid, r_a_last;
    logic [7:0]    r_a_red, r_a_green, r_a_blue;
    logic [CW-1:0] r_a_col;
    logic [RW-1:0] r_a_row;

    // stage B
    logic           r_b_valid, r_b_last;
    logic [15:0]    r_b_prod, r_b_bcol;
    logic [5:0]     r_b_lpos;
    logic [3:0]     r_b_cpos;
    t_pix_ctl       r_b_ctl;
    logic [LAW-1:0] r_b_idx;

    // stage C
    logic           r_c_valid, r_c_last;
    logic [15:0]    r_c_bidx;
    logic [5:0]     r_c_lpos;
    logic [3:0]     r_c_cpos;
    t_pix_ctl       r_c_ctl;
    logic [LAW-1:0] r_c_idx;

    // stage D: output register
    logic        r_d_valid, r_d_last, r_d_cvalid;
    logic [7:0]  r_d_luma, r_d_cb, r_d_cr;
    logic [15:0] r_d_bidx;
    logic [5:0]  r_d_lpos;
    logic [3:0]  r_d_cpos;

    logic [PW-1:0]  blk_prod;
    logic [31:0]    half_col;
    logic [7:0]     c_luma, c_cb, c_cr;
    t_chroma_res    c_chroma;

    // stages advance independently so bubbles collapse behind a stalled output
    always_comb begin
        en.ld_d = r_c_valid && (!r_d_valid || i_m_axis_tready);
        en.ld_c = r_b_valid && (!r_c_valid || en.ld_d);
        en.ld_b = r_a_valid && (!r_b_valid || en.ld_c);
    end

    assign o_s_axis_tready = !r_a_valid || en.ld_b;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= WEW'(eff_size(32'(WIDTH_RESET), 32'(MAX_WIDTH)));
            r_eff_h <= HEW'(eff_size(32'(HEIGHT_RESET), 32'(MAX_HEIGHT)));
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    r_eff_w <= WEW'(eff_size(32'(i_cfg_data[10:0]), 32'(MAX_WIDTH)));
                end
                REG_IMAGE_HEIGHT: begin
                    r_eff_h <= HEW'(eff_size(32'(i_cfg_data), 32'(MAX_HEIGHT)));
                end
                default: begin
                end
            endcase
        end
    end

    assign col_wrap = (32'(r_col) + 32'd1) >= 32'(r_eff_w);
    assign row_wrap = (32'(r_row) + 32'd1) >= 32'(r_eff_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (en.ld_b) begin
                r_a_valid <= 1'b0;
            end
            if (en.ld_b) begin
                r_b_valid <= 1'b1;
            end else if (en.ld_c) begin
                r_b_valid <= 1'b0;
            end
            if (en.ld_c) begin
                r_c_valid <= 1'b1;
            end else if (en.ld_d) begin
                r_c_valid <= 1'b0;
            end
            if (en.ld_d) begin
                r_d_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_d_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_red   <= i_s_axis_tdata[7:0];
            r_a_green <= i_s_axis_tdata[15:8];
            r_a_blue  <= i_s_axis_tdata[23:16];
            r_a_col   <= r_col;
            r_a_row   <= r_row;
            r_a_last  <= col_wrap && row_wrap;
        end
    end

    // line entry is (col/2) mod depth; col/2 never reaches twice the depth
    assign half_col = 32'(r_a_col[CW-1:1]);
    assign blk_prod = PW'(r_a_row[RW-1:3]) * PW'(r_eff_w[WEW-1:3]);

    always_ff @(posedge i_clk) begin
        if (en.ld_b) begin
            r_b_prod <= 16'(blk_prod);
            r_b_bcol <= 16'(r_a_col[CW-1:3]);
            r_b_lpos <= {r_a_row[2:0], r_a_col[2:0]};
            r_b_cpos <= {r_a_row[2:1], r_a_col[2:1]};
            r_b_ctl  <= '{col_odd: r_a_col[0], row_odd: r_a_row[0]};
            r_b_idx  <= (half_col >= 32'(LINE_DEPTH)) ? LAW'(half_col - 32'(LINE_DEPTH))
                                                       : LAW'(half_col);
            r_b_last <= r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.ld_c) begin
            r_c_bidx <= r_b_prod + r_b_bcol;
            r_c_lpos <= r_b_lpos;
            r_c_cpos <= r_b_cpos;
            r_c_ctl  <= r_b_ctl;
            r_c_idx  <= r_b_idx;
            r_c_last <= r_b_last;
        end
    end

    ry420_csc u_csc (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (r_a_red),
        .i_green (r_a_green),
        .i_blue  (r_a_blue),
        .o_luma  (c_luma),
        .o_cb    (c_cb),
        .o_cr    (c_cr)
    );

    ry420_chroma #(
        .LINE_DEPTH (LINE_DEPTH),
        .LAW        (LAW)
    ) u_chroma (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_rd_idx (r_b_idx),
        .i_wr_idx (r_c_idx),
        .i_ctl    (r_c_ctl),
        .i_cb     (c_cb),
        .i_cr     (c_cr),
        .o_chroma (c_chroma)
    );

    always_ff @(posedge i_clk) begin
        if (en.ld_d) begin
            r_d_luma   <= c_luma;
            r_d_bidx   <= r_c_bidx;
            r_d_lpos   <= r_c_lpos;
            r_d_cvalid <= c_chroma.valid;
            r_d_cb     <= c_chroma.cb_avg;
            r_d_cr     <= c_chroma.cr_avg;
            r_d_cpos   <= c_chroma.valid ? r_c_cpos : 4'd0;
            r_d_last   <= r_c_last;
        end
    end

    assign o_m_axis_tvalid = r_d_valid;
    assign o_m_axis_tdata  = {6'd0, r_d_cpos, r_d_cr, r_d_cb, r_d_lpos, r_d_bidx, r_d_luma};
    assign o_m_axis_tlast  = r_d_last;
    assign o_m_axis_tuser  = r_d_cvalid;

endmodule

>>> tb/ry420_tile_check.sv
// Monitor for the RGB to YCbCr 4:2:0 block tiler: predicts each result from the accepted
// pixels and size writes and compares the output stream field by field.
// Depends on ry420_pkg for the configuration port widths and register indexes.
`timescale 1ns / 1ps

module ry420_tile_check import ry420_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [23:0]           i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [55:0]           i_m_tdata,
    input  logic                  i_m_tlast,
    input  logic                  i_m_tuser,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_outstanding,
    output logic                  o_row_odd,
    output int                    o_line_fill    // entries of the pair line written so far
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    typedef struct packed {
        logic [7:0]  luma;
        logic [15:0] blk_index;
        logic [5:0]  luma_pos;
        logic        chroma_ok;
        logic [7:0]  cb_avg;
        logic [7:0]  cr_avg;
        logic [3:0]  chroma_pos;
        logic        last;
    } t_tile_pix;

    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    logic [17:0]  pair_line [LINE_DEPTH];
    logic [15:0]  left_pair;
    int unsigned  col_cnt;
    int unsigned  row_cnt;
    t_tile_pix    tile_q [$];
    int           result_no;

    function automatic logic [7:0] sat_q16(input longint acc);
        longint v;
        if (acc < 0) begin
            return 8'd0;
        end
        v = acc >>> 16;
        if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // low three bits dropped, then held within 8..limit
    function automatic int unsigned dim_in_use(input int unsigned raw, input int unsigned limit);
        int unsigned v;
        v = raw & ~32'd7;
        if (v < 8) begin
            v = 8;
        end
        if (v > limit) begin
            v = limit;
        end
        return v;
    endfunction

    task automatic tile_pixel(input logic [23:0] px);
        longint      r;
        longint      g;
        longint      b;
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int unsigned blk;
        logic [7:0]  y;
        logic [7:0]  cb;
        logic [7:0]  cr;
        logic [8:0]  cb_pair;
        logic [8:0]  cr_pair;
        logic [9:0]  cb_sum;
        logic [9:0]  cr_sum;
        logic [17:0] above;
        t_tile_pix   res;
        r = longint'(px[7:0]);
        g = longint'(px[15:8]);
        b = longint'(px[23:16]);
        w = dim_in_use(32'(width_reg), MAX_WIDTH);
        h = dim_in_use(32'(height_reg), MAX_HEIGHT);
        y  = sat_q16(19595 * r + 38470 * g + 7471 * b);
        cb = sat_q16(-11076 * r - 21692 * g + 32702 * b + (longint'(128) << 16));
        cr = sat_q16(32702 * r - 27394 * g - 5328 * b + (longint'(128) << 16));

        res = '0;
        res.luma = y;
        blk = (row_cnt >> 3) * (w >> 3) + (col_cnt >> 3);
        res.blk_index = blk[15:0];
        res.luma_pos = {row_cnt[2:0], col_cnt[2:0]};

        idx = (col_cnt >> 1) % LINE_DEPTH;
        if (!col_cnt[0]) begin
            left_pair = {cr, cb};
        end else begin
            cb_pair = {1'b0, left_pair[7:0]} + {1'b0, cb};
            cr_pair = {1'b0, left_pair[15:8]} + {1'b0, cr};
            if (!row_cnt[0]) begin
                pair_line[idx] = {cr_pair, cb_pair};
                if (idx == o_line_fill) begin
                    o_line_fill++;
                end
            end else begin
                above = pair_line[idx];
                cb_sum = {1'b0, above[8:0]} + {1'b0, cb_pair};
                cr_sum = {1'b0, above[17:9]} + {1'b0, cr_pair};
                res.cb_avg = cb_sum[9:2];
                res.cr_avg = cr_sum[9:2];
                res.chroma_ok = 1'b1;
                res.chroma_pos = {row_cnt[2:1], col_cnt[2:1]};
            end
        end

        // counters keep running across a size change; wrap once at or past the end
        res.last = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
        tile_q.push_back(res);
    endtask

    task automatic compare_result();
        t_tile_pix got;
        t_tile_pix want;
        got.luma       = i_m_tdata[7:0];
        got.blk_index  = i_m_tdata[23:8];
        got.luma_pos   = i_m_tdata[29:24];
        got.cb_avg     = i_m_tdata[37:30];
        got.cr_avg     = i_m_tdata[45:38];
        got.chroma_pos = i_m_tdata[49:46];
        got.chroma_ok  = i_m_tuser;
        got.last       = i_m_tlast;
        if (tile_q.size() == 0) begin
            if (o_errors < 10) begin
                $display("%t result %0d arrived with no pixel pending", $realtime, result_no);
            end
            o_errors++;
        end else begin
            want = tile_q.pop_front();
            if (got.luma != want.luma || got.blk_index != want.blk_index ||
                got.luma_pos != want.luma_pos || got.chroma_ok != want.chroma_ok ||
                got.cb_avg != want.cb_avg || got.cr_avg != want.cr_avg ||
                got.chroma_pos != want.chroma_pos || got.last != want.last) begin
                if (o_errors < 10) begin
                    $display("%t result %0d mismatch", $realtime, result_no);
                    $display("  exp: y=%0d blk=%0d pos=%0d cv=%b cb=%0d cr=%0d cpos=%0d last=%b",
                             want.luma, want.blk_index, want.luma_pos, want.chroma_ok,
                             want.cb_avg, want.cr_avg, want.chroma_pos, want.last);
                    $display("  act: y=%0d blk=%0d pos=%0d cv=%b cb=%0d cr=%0d cpos=%0d last=%b",
                             got.luma, got.blk_index, got.luma_pos, got.chroma_ok,
                             got.cb_avg, got.cr_avg, got.chroma_pos, got.last);
                end
                o_errors++;
            end
        end
        result_no++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg   = 11'(WIDTH_RESET);
            height_reg  = 13'(HEIGHT_RESET);
            left_pair   = '0;
            col_cnt     = 0;
            row_cnt     = 0;
            o_errors    = 0;
            o_line_fill = 0;
            result_no   = 0;
            tile_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                compare_result();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data[10:0];
                end else if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                    height_reg = i_cfg_data[12:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                tile_pixel(i_s_tdata);
            end
        end
        o_outstanding = tile_q.size();
        o_row_odd = row_cnt[0];
    end

endmodule

>>> tb/tb_rgb_to_ycbcr_420_block_tiler.sv
// Top of the block tiler testbench: clock, reset, pixel and size stimulus, output backpressure.
// Instantiates rgb_to_ycbcr_420_block_tiler and ry420_tile_check; uses ry420_pkg.
`timescale 1ns / 1ps

module tb_rgb_to_ycbcr_420_block_tiler;
    import ry420_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 4096;
    localparam int PIXEL_TARGET = 1550;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // luma[7:0], block_index[23:8], luma_position[29:24], cb_average[37:30],
    // cr_average[45:38], chroma_position[49:46], zero[55:50]
    logic [55:0]           o_m_axis_tdata;
    logic                  o_m_axis_tlast;   // frame_last
    logic                  o_m_axis_tuser;   // chroma_valid
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   err_count;
    int   outstanding;
    logic row_odd;
    int   line_fill;
    int   pixels_sent;
    int   quiet_cycles;
    logic [23:0] opening_px [24];

    rgb_to_ycbcr_420_block_tiler #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    ry420_tile_check #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .i_m_tlast     (o_m_axis_tlast),
        .i_m_tuser     (o_m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (err_count),
        .o_outstanding (outstanding),
        .o_row_odd     (row_odd),
        .o_line_fill   (line_fill)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready) ||
                     (o_m_axis_tvalid && i_m_axis_tready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [23:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        return {b, g, r};
    endfunction

    function automatic logic [23:0] random_pixel();
        logic [23:0] px;
        px = 24'($urandom);
        // saturated channels now and then to push the clamps
        if ($urandom_range(0, 5) == 0) begin
            px[7:0]   = $urandom_range(0, 1) ? 8'hff : 8'h00;
            px[15:8]  = $urandom_range(0, 1) ? 8'hff : 8'h00;
            px[23:16] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        return px;
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic push_pixel(input logic [23:0] px, input int gap);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = px;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_sizes(input int unsigned w_raw, input int unsigned h_raw);
        i_cfg_valid = 1'b1;
        i_cfg_index = REG_IMAGE_WIDTH;
        i_cfg_data  = w_raw[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index = REG_IMAGE_HEIGHT;
        i_cfg_data  = h_raw[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // output side: per-result stall, calm stretches, one long hold while input is busy
    initial begin
        int  taken;
        int  stall;
        bit  calm;
        bit  held;
        taken = 0;
        calm  = 1'b0;
        held  = 1'b0;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 64 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            stall = calm ? 0 : $urandom_range(0, 10);
            if (!held && taken >= 300 && i_s_axis_tvalid) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned w_raw;
        int unsigned h_raw;
        int          phase_len;
        bit          burst;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_IMAGE_WIDTH;
        i_cfg_data      = '0;
        pixels_sent     = 0;
        opening_px = '{
            rgb(8'h00, 8'h00, 8'h00), rgb(8'hff, 8'hff, 8'hff), rgb(8'hff, 8'h00, 8'h00),
            rgb(8'h00, 8'hff, 8'h00), rgb(8'h00, 8'h00, 8'hff), rgb(8'hff, 8'hff, 8'h00),
            rgb(8'h00, 8'hff, 8'hff), rgb(8'hff, 8'h00, 8'hff),
            rgb(8'hff, 8'hff, 8'hff), rgb(8'h00, 8'h00, 8'h00), rgb(8'h00, 8'h00, 8'hff),
            rgb(8'hff, 8'h00, 8'h00), rgb(8'h00, 8'hff, 8'hff), rgb(8'hff, 8'hff, 8'h00),
            rgb(8'hff, 8'h00, 8'hff), rgb(8'h00, 8'hff, 8'h00),
            rgb(8'h80, 8'h80, 8'h80), rgb(8'h01, 8'h01, 8'h01), rgb(8'hfe, 8'hfe, 8'hfe),
            rgb(8'h7f, 8'h7f, 8'h7f), rgb(8'ha5, 8'h5a, 8'h3c), rgb(8'h3c, 8'ha5, 8'h5a),
            rgb(8'h55, 8'haa, 8'h55), rgb(8'haa, 8'h55, 8'haa)
        };
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // sizes below range fall back to 8x8; two rows, then widen to the maxima mid-frame
        write_sizes(3, 0);
        for (int i = 0; i < 16; i++) begin
            push_pixel(opening_px[i], $urandom_range(0, 10));
        end
        drain();
        write_sizes(2047, 8191);
        for (int i = 16; i < 24; i++) begin
            push_pixel(opening_px[i], $urandom_range(0, 10));
        end

        while (pixels_sent < PIXEL_TARGET) begin
            drain();
            case ($urandom_range(0, 9))
                0:       w_raw = $urandom_range(0, 7);
                1:       w_raw = $urandom_range(1017, 2047);
                2:       w_raw = $urandom_range(0, 2047);
                default: w_raw = $urandom_range(8, 40);
            endcase
            case ($urandom_range(0, 9))
                0:       h_raw = $urandom_range(0, 7);
                1:       h_raw = $urandom_range(4089, 8191);
                2:       h_raw = $urandom_range(0, 8191);
                default: h_raw = $urandom_range(8, 24);
            endcase
            // on an odd row the new width must stay within what the even row above stored
            if (row_odd && w_raw > 2 * line_fill) begin
                w_raw = $urandom_range(0, 2 * line_fill);
            end
            write_sizes(w_raw, h_raw);
            burst = ($urandom_range(0, 3) == 0);
            phase_len = (w_raw > 64) ? $urandom_range(10, 60) : $urandom_range(30, 200);
            repeat (phase_len) begin
                push_pixel(random_pixel(), burst ? 0 : $urandom_range(0, 10));
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (err_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> rgb_to_ycbcr_420_block_tiler.f
sv/ry420_pkg.sv
sv/ry420_csc.sv
sv/ry420_chroma.sv
sv/rgb_to_ycbcr_420_block_tiler.sv
tb/ry420_tile_check.sv
tb/tb_rgb_to_ycbcr_420_block_tiler.sv
